### rtl/core/timestamped_history_interpolator_assert.svh
// Assertion macros for the history interpolator.
`ifndef TIMESTAMPED_HISTORY_INTERPOLATOR_ASSERT_SVH
`define TIMESTAMPED_HISTORY_INTERPOLATOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(name, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(name, clk_s, rst_s, ante, cons)
`endif

`endif

### rtl/core/thi_pkg.sv
`default_nettype none

package thi_pkg;

  localparam int HISTORY_DEPTH = 64;
  localparam int FRACTION_BITS = 16;

  localparam int ADDR_W  = $clog2(HISTORY_DEPTH);
  localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int QUO_W   = FRACTION_BITS + 1;
  localparam int DCNT_W  = $clog2(FRACTION_BITS + 1);
  localparam int DIFF_W  = 33;
  localparam int PROD_W  = QUO_W + 1 + DIFF_W;
  localparam int ENTRY_W = 64;

  localparam logic [COUNT_W-1:0] DEPTH_CNT = COUNT_W'(HISTORY_DEPTH);

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_OLD,
    S_CHK_OLD,
    S_CHK_NEW,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_PREP,
    S_DIV,
    S_MUL,
    S_SUM
  } state_t;

  // Physical slot of the k-th oldest sample.
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] base,
                                                 input logic [ADDR_W-1:0] k);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, k};
    if (s >= (ADDR_W + 1)'(HISTORY_DEPTH)) begin
      s = s - (ADDR_W + 1)'(HISTORY_DEPTH);
    end
    return s[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/thi_ram.sv
`default_nettype none

module thi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/timestamped_history_interpolator.sv
// Timestamped history interpolator.
// Request channel: start with cmd, sample_time, sample_value; a request is
// taken at a clock edge where start is high and busy is low.
// A push (cmd 0) stores the sample in a 64-entry ring memory in the cycle it
// is taken and leaves busy low, so requests may follow back to back; once
// the ring is full the oldest sample is overwritten.
// A query (cmd 1) on a non-empty history raises busy and runs a sequencer
// over the one memory read port: end checks, a binary search, a restoring
// divide of one quotient bit per cycle for the Q16 fraction, a multiply and
// an add. done pulses for one cycle with result_value and history_empty;
// busy is already low in that cycle, so the next request can be taken then.
// A query on an empty history answers without raising busy; one at either
// end stops after the end checks, and interpolating in a full history runs
// up to six search probes before the serial divider, multiply and add.
// The receiver cannot stall: a result is presented exactly once.
// Reset (rst, synchronous) empties the history; the memory is not cleared
// since entries are only read once written.
`default_nettype none

module timestamped_history_interpolator
  import thi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               cmd,
  input  wire logic        [31:0] sample_time,
  input  wire logic signed [31:0] sample_value,
  output logic                    done,
  output logic signed      [31:0] result_value,
  output logic                    history_empty
);

  `include "timestamped_history_interpolator_assert.svh"

  state_t state, state_next;

  logic [ADDR_W-1:0]  oldest_slot;
  logic [COUNT_W-1:0] sample_count;

  logic [31:0]        qt;
  logic [ADDR_W-1:0]  lo, hi;
  logic [31:0]        t_lo, t_hi;
  logic signed [31:0] v_lo, v_hi;
  logic [31:0]        gap;
  logic [32:0]        rem;
  logic [QUO_W-1:0]   quo;
  logic [DCNT_W-1:0]  div_cnt;
  logic signed [PROD_W-1:0] prod;

  logic               accept;
  logic               push_we;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rdata;
  logic [31:0]        rd_time;
  logic signed [31:0] rd_value;
  logic [ADDR_W-1:0]  last_idx;
  logic [ADDR_W:0]    mid_sum;
  logic [ADDR_W-1:0]  mid;
  logic               go_lo;
  logic [ADDR_W-1:0]  lo_next, hi_next;
  logic               fits;
  logic [32:0]        rem_sub;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] sum_full;

  logic               done_next;
  logic signed [31:0] result_next;
  logic               empty_next;

  assign busy     = (state != S_IDLE);
  assign accept   = start && !busy;
  assign push_we  = accept && (cmd == CMD_PUSH);
  assign waddr    = (sample_count == DEPTH_CNT) ? oldest_slot
                  : slot_of(oldest_slot, sample_count[ADDR_W-1:0]);
  assign rd_time  = rdata[63:32];
  assign rd_value = $signed(rdata[31:0]);
  assign last_idx = ADDR_W'(sample_count - COUNT_W'(1));
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid      = mid_sum[ADDR_W:1];
  assign go_lo    = (rd_time < qt);
  assign lo_next  = go_lo ? mid : lo;
  assign hi_next  = go_lo ? hi : mid;
  assign fits     = (rem >= {1'b0, gap});
  assign rem_sub  = fits ? (rem - {1'b0, gap}) : rem;
  assign diff     = $signed({v_hi[31], v_hi}) - $signed({v_lo[31], v_lo});
  assign sum_full = $signed({{(PROD_W - 32){v_lo[31]}}, v_lo})
                  + (prod >>> FRACTION_BITS);

  thi_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (push_we),
    .waddr(waddr),
    .wdata({sample_time, sample_value}),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    rd_addr     = oldest_slot;
    done_next   = 1'b0;
    result_next = 32'sd0;
    empty_next  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept && (cmd == CMD_QUERY)) begin
          if (sample_count == '0) begin
            done_next  = 1'b1;
            empty_next = 1'b1;
          end else begin
            state_next = S_RD_OLD;
          end
        end
      end
      S_RD_OLD: begin
        rd_addr    = slot_of(oldest_slot, '0);
        state_next = S_CHK_OLD;
      end
      S_CHK_OLD: begin
        rd_addr = slot_of(oldest_slot, last_idx);
        if ((sample_count == COUNT_W'(1)) || (qt <= rd_time)) begin
          done_next   = 1'b1;
          result_next = rd_value;
          state_next  = S_IDLE;
        end else begin
          state_next = S_CHK_NEW;
        end
      end
      S_CHK_NEW: begin
        if (qt >= rd_time) begin
          done_next   = 1'b1;
          result_next = rd_value;
          state_next  = S_IDLE;
        end else if (last_idx > ADDR_W'(1)) begin
          state_next = S_SRCH_RD;
        end else begin
          state_next = S_PREP;
        end
      end
      S_SRCH_RD: begin
        rd_addr    = slot_of(oldest_slot, mid);
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        state_next = ((hi_next - lo_next) > ADDR_W'(1)) ? S_SRCH_RD : S_PREP;
      end
      S_PREP: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DCNT_W'(FRACTION_BITS)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_SUM;
      end
      S_SUM: begin
        done_next   = 1'b1;
        result_next = sum_full[31:0];
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Ring pointers and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_slot  <= '0;
      sample_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= done_next;
      if (push_we) begin
        if (sample_count == DEPTH_CNT) begin
          oldest_slot <= slot_of(oldest_slot, ADDR_W'(1));
        end else begin
          sample_count <= sample_count + COUNT_W'(1);
        end
      end
    end
  end

  // Datapath registers of the query sequencer.
  always_ff @(posedge clk) begin
    if (done_next) begin
      result_value  <= result_next;
      history_empty <= empty_next;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          qt <= sample_time;
        end
      end
      S_CHK_OLD: begin
        t_lo <= rd_time;
        v_lo <= rd_value;
      end
      S_CHK_NEW: begin
        t_hi <= rd_time;
        v_hi <= rd_value;
        lo   <= '0;
        hi   <= last_idx;
      end
      S_SRCH_CHK: begin
        lo <= lo_next;
        hi <= hi_next;
        if (go_lo) begin
          t_lo <= rd_time;
          v_lo <= rd_value;
        end else begin
          t_hi <= rd_time;
          v_hi <= rd_value;
        end
      end
      S_PREP: begin
        rem     <= {1'b0, qt - t_lo};
        gap     <= (t_hi > t_lo) ? (t_hi - t_lo) : 32'd1;
        quo     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        // One quotient bit per cycle, most significant first.
        rem     <= {rem_sub[31:0], 1'b0};
        quo     <= {quo[QUO_W-2:0], fits};
        div_cnt <= div_cnt + DCNT_W'(1);
      end
      S_MUL: begin
        // Fraction is at most 17 bits and the value step 33 bits signed.
        prod <= $signed({{(PROD_W - QUO_W){1'b0}}, quo})
              * $signed({{(PROD_W - DIFF_W){diff[DIFF_W-1]}}, diff});
      end
      default: begin
      end
    endcase
  end

  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, sample_count <= DEPTH_CNT)
  `ASSERT_NEXT(a_push_silent, clk, rst, push_we, !done)
  `ASSERT_NEXT(a_query_runs, clk, rst, accept && (cmd == CMD_QUERY), busy || done)

endmodule

`default_nettype wire
